// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file sha_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Constants, command types and round constants for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int LEN_W   = 64;
  localparam int CNT_W   = 6;   // byte position inside a 64-byte block
  localparam int RND_W   = 6;   // round number 0..63
  localparam int IDX_W   = 3;   // digest word / length byte index

  localparam logic [BYTE_W-1:0] PAD_MARK  = 8'h80;
  localparam logic [CNT_W-1:0]  LEN_POS   = 6'd56;
  localparam logic [CNT_W-1:0]  LAST_POS  = 6'd63;
  localparam logic [RND_W-1:0]  LAST_RND  = 6'd63;
  localparam logic [IDX_W-1:0]  LAST_WORD = 3'd7;

  localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Source of the byte shifted into the message window.
  typedef enum logic [1:0] {
    BYTE_IN,
    BYTE_MARK,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_t;

  // Controller to datapath command bundle.
  typedef struct packed {
    logic             shift_byte;
    byte_sel_t        byte_sel;
    logic [IDX_W-1:0] len_idx;
    logic             add_len;
    logic             load_work;
    logic             round;
    logic [RND_W-1:0] rnd;
    logic             chain_add;
    logic             chain_init;
    logic             load_out;
    logic [IDX_W-1:0] out_idx;
  } dp_cmd_t;

endpackage

// File: hdl/sha_if.sv
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels for message items and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, output data_byte, output byte_present,
                  output message_end, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input message_end, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;

  modport source (output valid, output digest_word, output word_index,
                  output digest_last, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input digest_last, output ready);
endinterface

// File: hdl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, padding, round count and digest emission.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             byte_present,
  input  logic             message_end,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output sha_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_ZERO,
    S_LEN,
    S_ROUND,
    S_CHAIN,
    S_EMIT
  } state_t;

  // where to go once a block compression is done
  typedef enum logic [1:0] {
    RET_IDLE,
    RET_MARK,
    RET_ZERO,
    RET_EMIT
  } ret_t;

  state_t                     state_r, state_nxt;
  ret_t                       ret_r, ret_nxt;
  logic [sha_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [sha_pkg::RND_W-1:0]  rnd_r, rnd_nxt;
  logic [sha_pkg::IDX_W-1:0]  len_r, len_nxt;
  logic [sha_pkg::IDX_W-1:0]  emit_r, emit_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       wrap;

  assign wrap      = (cnt_r == sha_pkg::LAST_POS);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    len_nxt       = len_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && !out_ready;

    cmd.shift_byte = 1'b0;
    cmd.byte_sel   = sha_pkg::BYTE_IN;
    cmd.len_idx    = len_r;
    cmd.add_len    = 1'b0;
    cmd.load_work  = 1'b0;
    cmd.round      = 1'b0;
    cmd.rnd        = rnd_r;
    cmd.chain_add  = 1'b0;
    cmd.chain_init = 1'b0;
    cmd.load_out   = 1'b0;
    cmd.out_idx    = emit_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (byte_present) begin
            cmd.shift_byte = 1'b1;
            cmd.byte_sel   = sha_pkg::BYTE_IN;
            cmd.add_len    = 1'b1;
            cnt_nxt        = cnt_r + 6'd1;
            if (wrap) begin
              cmd.load_work = 1'b1;
              rnd_nxt       = '0;
              state_nxt     = S_ROUND;
              ret_nxt       = message_end ? RET_MARK : RET_IDLE;
            end else if (message_end) begin
              state_nxt = S_MARK;
            end
          end else if (message_end) begin
            state_nxt = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmd.shift_byte = 1'b1;
        cmd.byte_sel   = sha_pkg::BYTE_MARK;
        cnt_nxt        = cnt_r + 6'd1;
        if (wrap) begin
          cmd.load_work = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = S_ROUND;
          ret_nxt       = RET_ZERO;
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        if (cnt_r == sha_pkg::LEN_POS) begin
          len_nxt   = '0;
          state_nxt = S_LEN;
        end else begin
          cmd.shift_byte = 1'b1;
          cmd.byte_sel   = sha_pkg::BYTE_ZERO;
          cnt_nxt        = cnt_r + 6'd1;
          if (wrap) begin
            cmd.load_work = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = S_ROUND;
            ret_nxt       = RET_ZERO;
          end
        end
      end
      S_LEN: begin
        // length bytes, most significant first; the eighth one fills the block
        cmd.shift_byte = 1'b1;
        cmd.byte_sel   = sha_pkg::BYTE_LEN;
        cnt_nxt        = cnt_r + 6'd1;
        len_nxt        = len_r + 3'd1;
        if (wrap) begin
          cmd.load_work = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = S_ROUND;
          ret_nxt       = RET_EMIT;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == sha_pkg::LAST_RND) begin
          state_nxt = S_CHAIN;
        end
      end
      S_CHAIN: begin
        cmd.chain_add = 1'b1;
        unique case (ret_r)
          RET_IDLE: state_nxt = S_IDLE;
          RET_MARK: state_nxt = S_MARK;
          RET_ZERO: state_nxt = S_ZERO;
          RET_EMIT: begin
            emit_nxt  = '0;
            state_nxt = S_EMIT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          emit_nxt      = emit_r + 3'd1;
          if (emit_r == sha_pkg::LAST_WORD) begin
            // the last word is latched this cycle, so the chain can restart
            cmd.chain_init = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= RET_IDLE;
      cnt_r       <= '0;
      rnd_r       <= '0;
      len_r       <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      len_r       <= len_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/sha_dp.sv
// ----------------------------------------------------------------------------
// sha_dp
// Datapath: message window, round unit, chaining words, length and output.
// ----------------------------------------------------------------------------
module sha_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sha_pkg::dp_cmd_t           cmd,
  input  logic [sha_pkg::BYTE_W-1:0] data_byte,
  output logic [sha_pkg::WORD_W-1:0] digest_word,
  output logic [sha_pkg::IDX_W-1:0]  word_index,
  output logic                       digest_last
);

  localparam int WIN_W = 16 * sha_pkg::WORD_W;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Window of 16 words, oldest word in the top bits. Bytes and schedule
  // words both shift in at the bottom.
  logic [WIN_W-1:0]          win_r;
  logic [sha_pkg::WORD_W-1:0] work_r [8];
  logic [sha_pkg::WORD_W-1:0] chain_r [8];
  logic [sha_pkg::LEN_W-1:0]  bitlen_r;
  logic [sha_pkg::WORD_W-1:0] out_word_r;
  logic [sha_pkg::IDX_W-1:0]  out_idx_r;
  logic                       out_last_r;

  logic [sha_pkg::BYTE_W-1:0] byte_mux;
  logic [sha_pkg::WORD_W-1:0] w0, w1, w9, w14, w_new;
  logic [sha_pkg::WORD_W-1:0] s0, s1, ch, mj, t1, t2;

  assign w0  = win_r[WIN_W-1 -: 32];
  assign w1  = win_r[WIN_W-33 -: 32];
  assign w9  = win_r[WIN_W-1-9*32 -: 32];
  assign w14 = win_r[WIN_W-1-14*32 -: 32];

  always_comb begin
    unique case (cmd.byte_sel)
      sha_pkg::BYTE_IN:   byte_mux = data_byte;
      sha_pkg::BYTE_MARK: byte_mux = sha_pkg::PAD_MARK;
      sha_pkg::BYTE_ZERO: byte_mux = '0;
      sha_pkg::BYTE_LEN:  byte_mux = bitlen_r[{~cmd.len_idx, 3'b000} +: 8];
      default:            byte_mux = '0;
    endcase
  end

  always_comb begin
    w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
          + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;
    s1 = rotr(work_r[4], 6) ^ rotr(work_r[4], 11) ^ rotr(work_r[4], 25);
    ch = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    t1 = work_r[7] + s1 + ch + sha_pkg::ROUND_K[cmd.rnd] + w0;
    s0 = rotr(work_r[0], 2) ^ rotr(work_r[0], 13) ^ rotr(work_r[0], 22);
    mj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    t2 = s0 + mj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 8; j++) begin
        chain_r[j] <= sha_pkg::INIT_HASH[j];
        work_r[j]  <= '0;
      end
      bitlen_r <= '0;
    end else begin
      if (cmd.load_work) begin
        for (int j = 0; j < 8; j++) work_r[j] <= chain_r[j];
      end else if (cmd.round) begin
        work_r[7] <= work_r[6];
        work_r[6] <= work_r[5];
        work_r[5] <= work_r[4];
        work_r[4] <= work_r[3] + t1;
        work_r[3] <= work_r[2];
        work_r[2] <= work_r[1];
        work_r[1] <= work_r[0];
        work_r[0] <= t1 + t2;
      end
      if (cmd.chain_init) begin
        for (int j = 0; j < 8; j++) chain_r[j] <= sha_pkg::INIT_HASH[j];
      end else if (cmd.chain_add) begin
        for (int j = 0; j < 8; j++) chain_r[j] <= chain_r[j] + work_r[j];
      end
      if (cmd.chain_init) begin
        bitlen_r <= '0;
      end else if (cmd.add_len) begin
        bitlen_r <= bitlen_r + 64'd8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      win_r <= {win_r[WIN_W-9:0], byte_mux};
    end else if (cmd.round) begin
      win_r <= {win_r[WIN_W-33:0], w_new};
    end
    if (cmd.load_out) begin
      out_word_r <= chain_r[cmd.out_idx];
      out_idx_r  <= cmd.out_idx;
      out_last_r <= (cmd.out_idx == sha_pkg::LAST_WORD);
    end
  end

  assign digest_word = out_word_r;
  assign word_index  = out_idx_r;
  assign digest_last = out_last_r;

endmodule

// File: hdl/sha256_hash.sv
// ----------------------------------------------------------------------------
// sha256_hash
// SHA-256 hasher fed one message byte per item, emitting eight digest words.
// ----------------------------------------------------------------------------
// A byte that does not fill a block is taken and in_ready stays high. The
// byte that fills a 64-byte block starts a compression: the single round
// unit runs the 64 rounds, then the result is folded into the chaining
// words, and in_ready stays low until that is done. An item with
// message_end starts padding, which shifts in the pad bytes (0x80, zeros
// up to byte 56, then eight length bytes) and compresses one or two final
// blocks while in_ready stays low. The eight digest words then leave one
// per cycle while the sink is ready, H0 first, digest_last on the eighth;
// new items are taken once the last word is in the output register.
// ----------------------------------------------------------------------------
module sha256_hash (
  input  logic  clk,
  input  logic  rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  sha_pkg::dp_cmd_t cmd;

  sha_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .byte_present (in_ch.byte_present),
    .message_end  (in_ch.message_end),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .cmd          (cmd)
  );

  sha_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .digest_word (out_ch.digest_word),
    .word_index  (out_ch.word_index),
    .digest_last (out_ch.digest_last)
  );

endmodule

// File: hdl/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the digest output sequence, bound to sha256_hash.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        digest_last
);

  // a waiting word holds still
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index))

  // last flag goes with word seven only
  `CHK_IMPL(a_last_flag, clk, rst_n, out_valid, digest_last == (word_index == 3'd7))

  // no new item while a digest is only partly delivered
  `CHK_IMPL(a_no_in_mid, clk, rst_n, out_valid && !digest_last, !in_ready)

  // words of one digest follow back to back in order
  `CHK_NEXT(a_word_seq, clk, rst_n, out_valid && out_ready && !digest_last, out_valid && (word_index == $past(word_index) + 3'd1))

endmodule

bind sha256_hash sha_checker u_sha_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .digest_word (out_ch.digest_word),
  .word_index  (out_ch.word_index),
  .digest_last (out_ch.digest_last)
);
